[sv/swrr_pkg.sv]
// shared types, constants and register codes of the smooth weighted round-robin picker
package swrr_pkg;

  localparam int NUM_POOLS   = 3;
  localparam int MAX_TARGETS = 4;
  localparam int WEIGHT_BITS = 16;

  // fixed by the register map and the word fields
  localparam int CFG_POOLS   = 3;
  localparam int NUM_REGS    = 6;
  localparam int REG_BITS    = 64;
  localparam int CNT_BITS    = 3;
  localparam int IDX_BITS    = 3;
  localparam int POOL_BITS   = 2;
  localparam int TARGET_BITS = 2;
  localparam int CW_BITS     = 19;

  localparam int PIDX_BITS   = (NUM_POOLS > 1) ? $clog2(NUM_POOLS) : 1;
  localparam int TIDX_BITS   = (MAX_TARGETS > 1) ? $clog2(MAX_TARGETS) : 1;
  localparam int TOTAL_BITS  = WEIGHT_BITS + $clog2(MAX_TARGETS + 1);

  localparam logic [IDX_BITS-1:0] REG_HSM_WEIGHTS = 3'd0;
  localparam logic [IDX_BITS-1:0] REG_SVS_WEIGHTS = 3'd1;
  localparam logic [IDX_BITS-1:0] REG_TSS_WEIGHTS = 3'd2;
  localparam logic [IDX_BITS-1:0] REG_HSM_COUNT   = 3'd3;
  localparam logic [IDX_BITS-1:0] REG_SVS_COUNT   = 3'd4;
  localparam logic [IDX_BITS-1:0] REG_TSS_COUNT   = 3'd5;

  typedef logic signed [CW_BITS-1:0] cw_t;
  typedef logic [WEIGHT_BITS-1:0] weight_t;

  typedef struct packed {
    logic [REG_BITS-1:0] weights;
    logic [CNT_BITS-1:0] count;
  } pool_cfg_t;

  typedef struct packed {
    logic                 no_target;
    logic [TIDX_BITS-1:0] best;
  } pick_res_t;

  // weight field of one target; a field starting past the register reads as zero
  function automatic weight_t target_weight(logic [REG_BITS-1:0] regv, int idx);
    logic [REG_BITS-1:0] shifted;
    shifted = regv >> (idx * WEIGHT_BITS);
    return WEIGHT_BITS'(shifted);
  endfunction

endpackage

[sv/swrr_cfg.sv]
// configuration registers: per-pool weights and active counts
module swrr_cfg (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_write,
  input  logic [swrr_pkg::IDX_BITS-1:0]     cfg_index,
  input  logic [swrr_pkg::REG_BITS-1:0]     cfg_data,
  input  logic [swrr_pkg::PIDX_BITS-1:0]    pool_sel,
  output swrr_pkg::pool_cfg_t               pool_cfg,
  output logic                              clear
);

  logic [swrr_pkg::REG_BITS-1:0] weights [swrr_pkg::CFG_POOLS];
  logic [swrr_pkg::CNT_BITS-1:0] counts  [swrr_pkg::CFG_POOLS];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int p = 0; p < swrr_pkg::CFG_POOLS; p++) begin
        weights[p] <= '0;
        counts[p]  <= '0;
      end
    end else if (cfg_write) begin
      case (cfg_index)
        swrr_pkg::REG_HSM_WEIGHTS: weights[0] <= cfg_data;
        swrr_pkg::REG_SVS_WEIGHTS: weights[1] <= cfg_data;
        swrr_pkg::REG_TSS_WEIGHTS: weights[2] <= cfg_data;
        swrr_pkg::REG_HSM_COUNT:   counts[0]  <= cfg_data[swrr_pkg::CNT_BITS-1:0];
        swrr_pkg::REG_SVS_COUNT:   counts[1]  <= cfg_data[swrr_pkg::CNT_BITS-1:0];
        swrr_pkg::REG_TSS_COUNT:   counts[2]  <= cfg_data[swrr_pkg::CNT_BITS-1:0];
        default: ;
      endcase
    end
  end

  // any write inside the map restarts the schedule
  assign clear = cfg_write &&
                 (cfg_index < swrr_pkg::IDX_BITS'(swrr_pkg::NUM_REGS));

  assign pool_cfg.weights = weights[pool_sel];
  assign pool_cfg.count   = counts[pool_sel];

endmodule

[sv/swrr_pick.sv]
// one smooth weighted round-robin step over a pool row
module swrr_pick (
  input  logic                pool_ok,
  input  swrr_pkg::pool_cfg_t pool_cfg,
  input  swrr_pkg::cw_t       row     [swrr_pkg::MAX_TARGETS],
  output swrr_pkg::pick_res_t res,
  output swrr_pkg::cw_t       row_next [swrr_pkg::MAX_TARGETS]
);

  logic [swrr_pkg::MAX_TARGETS-1:0] active;
  swrr_pkg::weight_t                w     [swrr_pkg::MAX_TARGETS];
  swrr_pkg::cw_t                    added [swrr_pkg::MAX_TARGETS];
  logic [swrr_pkg::TOTAL_BITS-1:0]  total;
  swrr_pkg::cw_t                    best_val;
  logic [swrr_pkg::TIDX_BITS-1:0]   best;

  // count above the target limit saturates: index never reaches it
  always_comb begin
    total = '0;
    for (int i = 0; i < swrr_pkg::MAX_TARGETS; i++) begin
      active[i] = (32'(pool_cfg.count) > 32'(i));
      w[i]      = active[i] ? swrr_pkg::target_weight(pool_cfg.weights, i) : '0;
      total     = total + swrr_pkg::TOTAL_BITS'(w[i]);
      added[i]  = row[i] + swrr_pkg::CW_BITS'(w[i]);
    end
  end

  // strict greater keeps ties on the lowest index
  always_comb begin
    best     = '0;
    best_val = added[0];
    for (int i = 1; i < swrr_pkg::MAX_TARGETS; i++) begin
      if (active[i] && (added[i] > best_val)) begin
        best     = swrr_pkg::TIDX_BITS'(i);
        best_val = added[i];
      end
    end
  end

  always_comb begin
    for (int i = 0; i < swrr_pkg::MAX_TARGETS; i++) begin
      if (!active[i]) begin
        row_next[i] = row[i];
      end else if (best == swrr_pkg::TIDX_BITS'(i)) begin
        row_next[i] = added[i] - swrr_pkg::CW_BITS'(total);
      end else begin
        row_next[i] = added[i];
      end
    end
  end

  assign res.no_target = !pool_ok || (total == '0);
  assign res.best      = best;

endmodule

[sv/smooth_weighted_round_robin_core.sv]
// top level of the smooth weighted round-robin picker
// Picks one target out of one of three pools per request word, smooth weighted
// round-robin style: each active target of the named pool adds its weight to
// its running current weight, the largest current weight wins (ties to the
// lowest index) and the pool's total weight is taken off the winner. A pool
// with no active target or zero total weight, or a pool number past the last
// pool, answers no_target with target 0 and leaves its state alone. Throughput
// is one pick word per cycle while the result side is not stalled; an accepted
// word loads the input register, runs through the combinational pick step and
// loads the result register, from which the result can be taken.
// The current weights sit in flip-flops and a same-pool pick in the next cycle
// sees the update at once. Any config write inside the register map clears all
// current weights; write only while idle.
module smooth_weighted_round_robin_core (
  input  logic                               clk,
  input  logic                               rst,
  // configuration
  input  logic                               cfg_write,
  input  logic [swrr_pkg::IDX_BITS-1:0]      cfg_index,
  input  logic [swrr_pkg::REG_BITS-1:0]      cfg_data,
  // pick request words
  input  logic                               pick_valid,
  output logic                               pick_stall,
  input  logic [swrr_pkg::POOL_BITS-1:0]     pool,
  // result words
  output logic                               result_valid,
  input  logic                               result_stall,
  output logic [swrr_pkg::TARGET_BITS-1:0]   target,
  output logic                               no_target
);

  // input register
  logic                              in_valid;
  logic [swrr_pkg::POOL_BITS-1:0]    pool_r;

  // current weights, one row per pool
  swrr_pkg::cw_t cw [swrr_pkg::NUM_POOLS][swrr_pkg::MAX_TARGETS];

  logic                              advance;
  logic                              pool_ok;
  logic [swrr_pkg::PIDX_BITS-1:0]    pool_sel;
  swrr_pkg::pool_cfg_t               pool_cfg;
  logic                              clear;
  swrr_pkg::cw_t                     row      [swrr_pkg::MAX_TARGETS];
  swrr_pkg::cw_t                     row_next [swrr_pkg::MAX_TARGETS];
  swrr_pkg::pick_res_t               res;

  // result register moves when empty or being taken
  assign advance    = !result_valid || !result_stall;
  assign pick_stall = in_valid && !advance;

  // out-of-range pool numbers read row zero but never write it
  assign pool_ok  = (32'(pool_r) < swrr_pkg::NUM_POOLS);
  assign pool_sel = pool_ok ? swrr_pkg::PIDX_BITS'(pool_r) : '0;

  always_comb begin
    for (int i = 0; i < swrr_pkg::MAX_TARGETS; i++) begin
      row[i] = cw[pool_sel][i];
    end
  end

  swrr_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .pool_sel  (pool_sel),
    .pool_cfg  (pool_cfg),
    .clear     (clear)
  );

  swrr_pick u_pick (
    .pool_ok  (pool_ok),
    .pool_cfg (pool_cfg),
    .row      (row),
    .res      (res),
    .row_next (row_next)
  );

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!pick_stall) begin
      in_valid <= pick_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (pick_valid && !pick_stall) begin
      pool_r <= pool;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance) begin
      result_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && in_valid) begin
      no_target <= res.no_target;
      target    <= res.no_target ? '0 : swrr_pkg::TARGET_BITS'(res.best);
    end
  end

  // current weight update, config clear first
  always_ff @(posedge clk) begin
    if (rst || clear) begin
      for (int p = 0; p < swrr_pkg::NUM_POOLS; p++) begin
        for (int i = 0; i < swrr_pkg::MAX_TARGETS; i++) begin
          cw[p][i] <= '0;
        end
      end
    end else if (in_valid && advance && !res.no_target) begin
      for (int i = 0; i < swrr_pkg::MAX_TARGETS; i++) begin
        cw[pool_sel][i] <= row_next[i];
      end
    end
  end

  // a result with no target always names target zero
  assert property (@(posedge clk) disable iff (rst)
    result_valid && no_target |-> target == '0)
    else $error("no_target result with nonzero target");

  // the request side is held back only by a stalled full result register
  assert property (@(posedge clk) disable iff (rst)
    pick_stall |-> in_valid && result_valid && result_stall)
    else $error("pick stalled without a blocked result");

  // a word leaving the input register shows up as a result next cycle
  assert property (@(posedge clk) disable iff (rst)
    in_valid && advance |=> result_valid)
    else $error("picked word lost between registers");

  // a pool number past the last pool never picks a target
  assert property (@(posedge clk) disable iff (rst)
    in_valid && advance && !pool_ok |=> no_target)
    else $error("target picked from a missing pool");

  // a config clear leaves the first current weight at zero
  assert property (@(posedge clk) disable iff (rst)
    clear |=> cw[0][0] == '0)
    else $error("current weights not cleared by config write");

endmodule

[dv/smooth_weighted_round_robin_core_tb.sv]
// self-checking testbench of the smooth weighted round-robin picker
module smooth_weighted_round_robin_core_tb;

  // run length guard and drain tail, in clock cycles
  localparam int CYCLE_LIMIT = 400000;
  localparam int LAT_TAIL    = 8;
  localparam int HOLD_LEN    = 150;
  localparam int RAND_ITEMS  = 1950;

  // register indexes just past the map and at the top of the index range
  localparam logic [swrr_pkg::IDX_BITS-1:0] REG_PAST_MAP =
    swrr_pkg::IDX_BITS'(swrr_pkg::NUM_REGS);
  localparam logic [swrr_pkg::IDX_BITS-1:0] REG_TOP_INDEX = '1;

  // pool number with no pool behind it
  localparam logic [swrr_pkg::POOL_BITS-1:0] POOL_MISSING = '1;

  // one result word as the block presents it
  typedef struct packed {
    logic [swrr_pkg::TARGET_BITS-1:0] target;
    logic                             no_target;
  } winner_t;

  logic                             clk = 1'b0;
  logic                             rst = 1'b1;
  logic                             cfg_write = 1'b0;
  logic [swrr_pkg::IDX_BITS-1:0]    cfg_index = '0;
  logic [swrr_pkg::REG_BITS-1:0]    cfg_data = '0;
  logic                             pick_valid = 1'b0;
  logic                             pick_stall;
  logic [swrr_pkg::POOL_BITS-1:0]   pool = '0;
  logic                             result_valid;
  logic                             result_stall = 1'b0;
  logic [swrr_pkg::TARGET_BITS-1:0] target;
  logic                             no_target;

  // shadow copy of the register map and the running current weights
  logic [swrr_pkg::REG_BITS-1:0] pool_wts [swrr_pkg::CFG_POOLS];
  logic [swrr_pkg::CNT_BITS-1:0] pool_cnt [swrr_pkg::CFG_POOLS];
  swrr_pkg::cw_t                 run_wt [swrr_pkg::CFG_POOLS][swrr_pkg::MAX_TARGETS];

  // request words still to be sent, and winners still to come back
  logic [swrr_pkg::POOL_BITS-1:0] pool_q [$];
  winner_t                        winner_q [$];

  // idling knobs, set by the sequencer at the falling edge while idle
  bit idle_tx = 1'b0;
  bit idle_rx = 1'b0;
  bit want_hold = 1'b0;
  bit hold_done = 1'b0;

  int send_gap = 0;
  int stall_left = 0;
  int hold_left = 0;
  int cycles = 0;
  int mismatches = 0;
  int picks_sent = 0;
  int results_seen = 0;
  int empty_picks = 0;
  int writes_done = 0;
  int pool_hits [4] = '{0, 0, 0, 0};

  smooth_weighted_round_robin_core uut (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .pick_valid   (pick_valid),
    .pick_stall   (pick_stall),
    .pool         (pool),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .target       (target),
    .no_target    (no_target)
  );

  always #6 clk = ~clk;

  // gap length: mostly none, often short, now and then long
  function automatic int draw_gap(input bit on);
    int r;
    if (!on) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(5, 20);
  endfunction

  // smooth weighted round-robin step on the shadow state, one winner per pick
  function automatic winner_t pick_winner(input logic [swrr_pkg::POOL_BITS-1:0] p);
    winner_t           res;
    swrr_pkg::weight_t w [swrr_pkg::MAX_TARGETS];
    int n;
    int total;
    int best;
    res.target = '0;
    res.no_target = 1'b1;
    // a pool number past the last pool never touches any state
    if (p >= swrr_pkg::NUM_POOLS) return res;
    // counts above the target limit saturate
    n = (pool_cnt[p] > swrr_pkg::MAX_TARGETS) ? swrr_pkg::MAX_TARGETS : int'(pool_cnt[p]);
    total = 0;
    for (int i = 0; i < n; i++) begin
      w[i] = pool_wts[p][i*swrr_pkg::WEIGHT_BITS +: swrr_pkg::WEIGHT_BITS];
      total += w[i];
    end
    // empty pool or all-zero weights: no winner, state left alone
    if (n == 0 || total == 0) return res;
    best = 0;
    for (int i = 0; i < n; i++) begin
      run_wt[p][i] = run_wt[p][i] + swrr_pkg::cw_t'(w[i]);
      if (i == 0 || run_wt[p][i] > run_wt[p][best]) best = i;
    end
    // winner pays back the pool total; inactive targets are never touched
    run_wt[p][best] = run_wt[p][best] - swrr_pkg::cw_t'(total);
    res.target = best[swrr_pkg::TARGET_BITS-1:0];
    res.no_target = 1'b0;
    return res;
  endfunction

  // request driver: holds a word until taken, then maybe idles before the next
  always @(posedge clk) begin
    if (rst) begin
      pick_valid <= 1'b0;
    end else begin
      if (pick_valid && !pick_stall) begin
        winner_q = {winner_q, pick_winner(pool)};
        picks_sent++;
        pool_hits[pool]++;
      end
      if (!pick_valid || !pick_stall) begin
        if (send_gap > 0) begin
          send_gap <= send_gap - 1;
          pick_valid <= 1'b0;
        end else if (pool_q.size() != 0) begin
          pick_valid <= 1'b1;
          pool <= pool_q.pop_front();
          send_gap <= draw_gap(idle_tx);
        end else begin
          pick_valid <= 1'b0;
        end
      end
    end
  end

  // result monitor: checks each accepted word and drives the stall pattern
  always @(posedge clk) begin
    winner_t exp_w;
    int g;
    if (rst) begin
      result_stall <= 1'b0;
    end else begin
      if (result_valid && !result_stall) begin
        results_seen++;
        if (winner_q.size() == 0) begin
          $error("result word with no pick pending: target %0d no_target %0d",
                 target, no_target);
          mismatches++;
        end else begin
          exp_w = winner_q.pop_front();
          if (exp_w.no_target) empty_picks++;
          if (target !== exp_w.target) begin
            $error("target mismatch: expected %0d, actual %0d", exp_w.target, target);
            mismatches++;
          end
          if (no_target !== exp_w.no_target) begin
            $error("no_target mismatch: expected %0d, actual %0d",
                   exp_w.no_target, no_target);
            mismatches++;
          end
        end
      end
      // long hold-off counted here so the block fills and stalls its input
      if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        result_stall <= 1'b1;
      end else if (want_hold && !hold_done) begin
        hold_left <= HOLD_LEN - 1;
        hold_done <= 1'b1;
        result_stall <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left <= stall_left - 1;
        result_stall <= 1'b1;
      end else begin
        g = draw_gap(idle_rx);
        stall_left <= (g > 0) ? g - 1 : 0;
        result_stall <= (g > 0);
      end
    end
  end

  // guard against a hung handshake
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("smooth_weighted_round_robin_core_tb: FAIL");
      $finish;
    end
  end

  // one register write; any index inside the map clears the running weights
  task automatic reg_write(input logic [swrr_pkg::IDX_BITS-1:0] idx,
                           input logic [swrr_pkg::REG_BITS-1:0] val);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_write <= 1'b0;
    if (idx < swrr_pkg::NUM_REGS) begin
      if (idx <= swrr_pkg::REG_TSS_WEIGHTS)
        pool_wts[swrr_pkg::PIDX_BITS'(idx - swrr_pkg::REG_HSM_WEIGHTS)] = val;
      else
        pool_cnt[swrr_pkg::PIDX_BITS'(idx - swrr_pkg::REG_HSM_COUNT)] =
          val[swrr_pkg::CNT_BITS-1:0];
      foreach (run_wt[a, b]) run_wt[a][b] = '0;
    end
    writes_done++;
  endtask

  // wait until every sent word has come back, then a short tail
  task automatic drain_all();
    while (pool_q.size() != 0 || pick_valid || winner_q.size() != 0) @(negedge clk);
    repeat (LAT_TAIL) @(negedge clk);
  endtask

  // weight register mixing zeros, ones, full scale, small and wide values
  function automatic logic [swrr_pkg::REG_BITS-1:0] rand_weights();
    logic [swrr_pkg::REG_BITS-1:0] v;
    v = '0;
    for (int k = 0; k < swrr_pkg::MAX_TARGETS; k++) begin
      case ($urandom_range(0, 5))
        0: v[k*swrr_pkg::WEIGHT_BITS +: swrr_pkg::WEIGHT_BITS] = '0;
        1: v[k*swrr_pkg::WEIGHT_BITS +: swrr_pkg::WEIGHT_BITS] = '1;
        2: v[k*swrr_pkg::WEIGHT_BITS +: swrr_pkg::WEIGHT_BITS] = swrr_pkg::WEIGHT_BITS'(1);
        3, 4: v[k*swrr_pkg::WEIGHT_BITS +: swrr_pkg::WEIGHT_BITS] =
          swrr_pkg::WEIGHT_BITS'($urandom_range(1, 12));
        default: v[k*swrr_pkg::WEIGHT_BITS +: swrr_pkg::WEIGHT_BITS] =
          swrr_pkg::WEIGHT_BITS'($urandom);
      endcase
    end
    return v;
  endfunction

  // count register: mostly in range, some saturating, some junk in upper bits
  function automatic logic [swrr_pkg::REG_BITS-1:0] rand_count();
    logic [swrr_pkg::REG_BITS-1:0] v;
    int r;
    r = $urandom_range(0, 11);
    v = ($urandom_range(0, 1) != 0) ? {$urandom, $urandom} : '0;
    v[swrr_pkg::CNT_BITS-1:0] = (r <= 7) ? swrr_pkg::CNT_BITS'(r)
                                         : swrr_pkg::CNT_BITS'($urandom_range(1, 4));
    return v;
  endfunction

  // a batch of random pool numbers, the odd one past the last pool
  task automatic push_random(input int n);
    @(negedge clk);
    for (int k = 0; k < n; k++)
      pool_q = {pool_q, ($urandom_range(0, 19) == 0) ? POOL_MISSING
                        : swrr_pkg::POOL_BITS'($urandom_range(0, 2))};
  endtask

  initial begin
    int rand_sent;
    int batch;
    int phase;
    foreach (pool_wts[a]) begin
      pool_wts[a] = '0;
      pool_cnt[a] = '0;
    end
    foreach (run_wt[a, b]) run_wt[a][b] = '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // straight out of reset every pool is empty
    @(negedge clk);
    pool_q = '{2'd0, 2'd1, 2'd2, 2'd3};
    drain_all();

    // full-scale weights, saturated count, zero-weight tail, empty pool with weights
    reg_write(swrr_pkg::REG_HSM_WEIGHTS, '1);
    reg_write(swrr_pkg::REG_HSM_COUNT, 64'd4);
    reg_write(swrr_pkg::REG_SVS_WEIGHTS, 64'h0000_0000_0001_0005);
    reg_write(swrr_pkg::REG_SVS_COUNT, '1);
    reg_write(swrr_pkg::REG_TSS_WEIGHTS, 64'h0003_0000_0002_0001);
    reg_write(swrr_pkg::REG_TSS_COUNT, 64'd0);
    @(negedge clk);
    pool_q = '{2'd0, 2'd0, 2'd0, 2'd0, 2'd1, 2'd1, 2'd1, 2'd1, 2'd1, 2'd1,
               2'd2, 2'd3, 2'd0, 2'd1};
    drain_all();

    // writes past the register map must leave the running weights alone
    reg_write(REG_PAST_MAP, {$urandom, $urandom});
    reg_write(REG_TOP_INDEX, '1);
    @(negedge clk);
    pool_q = '{2'd1, 2'd1, 2'd0};
    drain_all();

    // zero-weight target inside an active pool, then an all-zero pool
    reg_write(swrr_pkg::REG_TSS_COUNT, 64'd4);
    reg_write(swrr_pkg::REG_SVS_WEIGHTS, '0);
    @(negedge clk);
    pool_q = '{2'd2, 2'd2, 2'd2, 2'd2, 2'd1};
    drain_all();

    // random phases, each under its own register values and idling mix
    rand_sent = 0;
    phase = 0;
    while (rand_sent < RAND_ITEMS) begin
      if (phase == 0) begin
        reg_write(swrr_pkg::REG_HSM_WEIGHTS, rand_weights());
        reg_write(swrr_pkg::REG_SVS_WEIGHTS, rand_weights());
        reg_write(swrr_pkg::REG_TSS_WEIGHTS, rand_weights());
        reg_write(swrr_pkg::REG_HSM_COUNT, rand_count());
        reg_write(swrr_pkg::REG_SVS_COUNT, rand_count());
        reg_write(swrr_pkg::REG_TSS_COUNT, rand_count());
      end else begin
        for (int r = 0; r < swrr_pkg::NUM_REGS; r++) begin
          if ($urandom_range(0, 2) == 0)
            reg_write(r[swrr_pkg::IDX_BITS-1:0],
                      (r < swrr_pkg::CFG_POOLS) ? rand_weights() : rand_count());
        end
        if ($urandom_range(0, 9) == 0)
          reg_write(($urandom_range(0, 1) != 0) ? REG_TOP_INDEX : REG_PAST_MAP,
                    {$urandom, $urandom});
      end
      @(negedge clk);
      if (phase == 2) begin
        // sender streams flat out while the receiver sits on its stall
        idle_tx = 1'b0;
        idle_rx = 1'b0;
        batch = 300;
        push_random(batch);
        @(negedge clk);
        want_hold = 1'b1;
      end else begin
        idle_tx = ($urandom_range(0, 1) != 0);
        idle_rx = ($urandom_range(0, 1) != 0);
        batch = $urandom_range(20, 120);
        push_random(batch);
      end
      drain_all();
      rand_sent += batch;
      phase++;
    end

    drain_all();
    $display("covered %0d picks (pools 0..3: %0d %0d %0d %0d), %0d with no target,",
             picks_sent, pool_hits[0], pool_hits[1], pool_hits[2], pool_hits[3],
             empty_picks);
    $display("  %0d register writes over %0d random phases, %0d results checked",
             writes_done, phase, results_seen);
    if (mismatches == 0) begin
      $display("smooth_weighted_round_robin_core_tb: PASS");
    end else begin
      $display("smooth_weighted_round_robin_core_tb: FAIL");
    end
    $finish;
  end

endmodule
